@@ rtl/core/cmfr_pkg.sv @@
// ----------------------------------------------------------------------------
// cmfr_pkg
// shared constants for the can multi-frame reassembler: buffer size default,
// header and tail marker bytes, status codes
// ----------------------------------------------------------------------------
package cmfr_pkg;

    // default buffer size in bytes
    localparam int BUF_BYTES_DEF = 256;

    // byte lanes of one can frame
    localparam int LANES = 8;

    // header marker, bytes 0..3 of a header frame
    localparam logic [7:0] HDR_B0 = 8'h55;
    localparam logic [7:0] HDR_B1 = 8'haa;
    localparam logic [7:0] HDR_B2 = 8'h55;
    localparam logic [7:0] HDR_B3 = 8'haa;

    // tail marker, the four bytes after the payload
    localparam logic [7:0] TAIL_B0 = 8'h66;
    localparam logic [7:0] TAIL_B1 = 8'hcc;
    localparam logic [7:0] TAIL_B2 = 8'h66;
    localparam logic [7:0] TAIL_B3 = 8'hcc;

    // number of tail bytes
    localparam int TAIL_LEN = 4;

    // result status codes
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_HDR_OK   = 3'd1;
    localparam logic [2:0] ST_HDR_BIG  = 3'd2;
    localparam logic [2:0] ST_MSG_OK   = 3'd3;
    localparam logic [2:0] ST_TAIL_BAD = 3'd4;
    localparam logic [2:0] ST_READ     = 3'd5;

endpackage

@@ rtl/core/cmfr_ram.sv @@
// ----------------------------------------------------------------------------
// cmfr_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module cmfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/can_multi_frame_reassembler_top.sv @@
// ----------------------------------------------------------------------------
// can_multi_frame_reassembler_top
// reassembles a multi-frame message out of can frames: a header frame
// (55 aa 55 aa, length in bytes 6..7) opens a message, data frames fill the
// byte buffer until payload plus tail have arrived, the tail is checked
// against 66 cc 66 cc; read items return eight buffered bytes
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  input   | in_valid / in_ready  | func, frame_len, frame_bytes, read_word
//  output  | out_valid / out_ready| status, message_length, read_bytes
//
//  - one item per cycle sustained while out_ready stays high; out_valid rises
//    after the input accept, once the item has passed the input register,
//    then the result register plus registered ram read
//  - the buffer is eight byte-lane rams, one byte of each lane per frame,
//    so a frame of up to eight bytes lands in a single write at any alignment
//  - reset clears the control state only; the buffer needs no clearing pass
//  - with out_ready low the result holds and one more item waits in the
//    input register, after which in_ready drops
// ----------------------------------------------------------------------------
module can_multi_frame_reassembler_top #(
    parameter int BUF_BYTES = cmfr_pkg::BUF_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [3:0]  frame_len,
    input  logic [63:0] frame_bytes,
    input  logic [4:0]  read_word,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [7:0]  message_length,
    output logic [63:0] read_bytes
);

    localparam int LANES = cmfr_pkg::LANES;
    // payload length never exceeds BUF_BYTES - 4
    localparam int PL_W  = $clog2(BUF_BYTES);
    // write position runs up to BUF_BYTES inclusive
    localparam int WP_W  = $clog2(BUF_BYTES + 1);
    // rows of each byte-lane ram
    localparam int ROWS  = (BUF_BYTES + LANES - 1) / LANES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [16:0] BUF_LIM = 17'(BUF_BYTES);

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic in_accept;
    logic s1_adv;

    assign s1_adv    = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_accept = in_valid && in_ready;
    assign out_valid = s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic        s1_func_reg;
    logic [3:0]  s1_flen_reg;
    logic [63:0] s1_bytes_reg;
    logic [4:0]  s1_word_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg  <= func;
            s1_flen_reg  <= frame_len;
            s1_bytes_reg <= frame_bytes;
            s1_word_reg  <= read_word;
        end
    end

    // ------------------------------------------------------------------
    // assembly state
    // ------------------------------------------------------------------
    logic            assembling_reg;
    logic            assembling_next;
    logic [PL_W-1:0] pl_reg;
    logic [PL_W-1:0] pl_next;
    logic [WP_W-1:0] wp_reg;
    logic [WP_W-1:0] wp_next;
    // last four bytes written, oldest in the low byte
    logic [31:0]     tail_reg;

    logic            is_read;
    logic            is_hdr;
    logic [15:0]     hdr_len;
    logic            hdr_big;
    logic [3:0]      flen8;
    logic [WP_W-1:0] end_pos;
    logic [WP_W-1:0] remaining;
    logic            wr_active;
    logic [3:0]      take;
    logic [WP_W-1:0] wp_sum;
    logic            done;
    logic [95:0]     tail_seq;
    logic [31:0]     tail_new;
    logic            tail_good;
    logic [2:0]      status_next;
    logic [31:0]     pl_next_ext;

    assign is_read = s1_func_reg;
    // header detection ignores frame_len
    assign is_hdr  = (s1_bytes_reg[7:0]   == cmfr_pkg::HDR_B0)
                  && (s1_bytes_reg[15:8]  == cmfr_pkg::HDR_B1)
                  && (s1_bytes_reg[23:16] == cmfr_pkg::HDR_B2)
                  && (s1_bytes_reg[31:24] == cmfr_pkg::HDR_B3);
    assign hdr_len = s1_bytes_reg[63:48];
    assign hdr_big = ({1'b0, hdr_len} + 17'(cmfr_pkg::TAIL_LEN)) > BUF_LIM;

    // lengths above eight count as eight
    assign flen8     = (s1_flen_reg > 4'(LANES)) ? 4'(LANES) : s1_flen_reg;
    assign end_pos   = WP_W'(pl_reg) + WP_W'(cmfr_pkg::TAIL_LEN);
    assign remaining = end_pos - wp_reg;
    assign wr_active = !is_read && !is_hdr && assembling_reg;

    // surplus bytes past the tail are dropped
    always_comb
    begin
        if (!wr_active)
        begin
            take = 4'd0;
        end
        else if (remaining < WP_W'(flen8))
        begin
            take = 4'(remaining);
        end
        else
        begin
            take = flen8;
        end
    end

    assign wp_sum = wp_reg + WP_W'(take);
    assign done   = wr_active && (wp_sum == end_pos);

    // the tail is always the last four bytes written before the end
    assign tail_seq  = {s1_bytes_reg, tail_reg};
    assign tail_new  = tail_seq[{take, 3'b000} +: 32];
    assign tail_good = (tail_new == {cmfr_pkg::TAIL_B3, cmfr_pkg::TAIL_B2,
                                     cmfr_pkg::TAIL_B1, cmfr_pkg::TAIL_B0});

    always_comb
    begin
        assembling_next = assembling_reg;
        pl_next         = pl_reg;
        wp_next         = wp_reg;
        status_next     = cmfr_pkg::ST_IDLE;
        priority if (is_read)
        begin
            status_next = cmfr_pkg::ST_READ;
        end
        else if (is_hdr)
        begin
            // an oversized header leaves any assembly untouched
            if (hdr_big)
            begin
                status_next = cmfr_pkg::ST_HDR_BIG;
            end
            else
            begin
                pl_next         = PL_W'(hdr_len);
                wp_next         = '0;
                assembling_next = 1'b1;
                status_next     = cmfr_pkg::ST_HDR_OK;
            end
        end
        else if (assembling_reg)
        begin
            wp_next = wp_sum;
            if (done)
            begin
                assembling_next = 1'b0;
                status_next     = tail_good ? cmfr_pkg::ST_MSG_OK
                                            : cmfr_pkg::ST_TAIL_BAD;
            end
        end
    end

    assign pl_next_ext = 32'(pl_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            assembling_reg <= 1'b0;
            pl_reg         <= '0;
            wp_reg         <= '0;
        end
        else if (s1_adv)
        begin
            assembling_reg <= assembling_next;
            pl_reg         <= pl_next;
            wp_reg         <= wp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && wr_active)
        begin
            tail_reg <= tail_new;
        end
    end

    // ------------------------------------------------------------------
    // byte-lane buffer: byte address a lives in lane a%8, row a/8
    // ------------------------------------------------------------------
    logic             lane_we   [LANES];
    logic [ROW_W-1:0] lane_wrow [LANES];
    logic [7:0]       lane_wdat [LANES];
    logic [7:0]       lane_rdat [LANES];
    logic [ROW_W-1:0] rd_row;
    logic             rd_en;
    logic [LANES-1:0] rd_mask;

    always_comb
    begin
        logic [2:0]      off;
        logic [WP_W-1:0] addr;
        for (int l = 0; l < LANES; l++)
        begin
            // frame byte index that lands in this lane
            off          = 3'(l) - wp_reg[2:0];
            addr         = wp_reg + WP_W'(off);
            lane_we[l]   = s1_adv && ({1'b0, off} < take);
            lane_wrow[l] = ROW_W'(addr >> 3);
            lane_wdat[l] = s1_bytes_reg[{off, 3'b000} +: 8];
        end
    end

    assign rd_row = ROW_W'(32'(s1_word_reg));
    assign rd_en  = s1_adv && is_read;

    // byte positions at or above the buffer size read as zero
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rd_mask[l] = is_read
                      && ({24'd0, s1_word_reg, 3'(l)} < 32'(BUF_BYTES));
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        cmfr_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_lane_ram (
            .clk   (clk),
            .we    (lane_we[g]),
            .waddr (lane_wrow[g]),
            .wdata (lane_wdat[g]),
            .re    (rd_en),
            .raddr (rd_row),
            .rdata (lane_rdat[g])
        );
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic [2:0]       s2_status_reg;
    logic [7:0]       s2_len_reg;
    logic [LANES-1:0] s2_mask_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_status_reg <= status_next;
            s2_len_reg    <= pl_next_ext[7:0];
            s2_mask_reg   <= rd_mask;
        end
    end

    assign status         = s2_status_reg;
    assign message_length = s2_len_reg;

    // ram read data holds while the result waits, frame items mask it off
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            read_bytes[8*l +: 8] = s2_mask_reg[l] ? lane_rdat[l] : 8'd0;
        end
    end

`ifndef SYNTHESIS
    // write position never passes the end of the message being assembled
    a_wp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        assembling_reg |-> (wp_reg < end_pos))
        else $error("write position past end of message");

    // an accepted header always leaves room for payload and tail
    a_len_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(pl_reg) + 32'(cmfr_pkg::TAIL_LEN)) <= 32'(BUF_BYTES))
        else $error("payload length exceeds buffer");

    // an oversized header leaves the assembly state alone
    a_big_hdr_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !is_read && is_hdr && hdr_big) |=>
            (assembling_reg == $past(assembling_reg))
            && (pl_reg == $past(pl_reg)) && (wp_reg == $past(wp_reg)))
        else $error("oversized header changed assembly state");

    // a completed message closes the assembly
    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((status == cmfr_pkg::ST_MSG_OK)
                    || (status == cmfr_pkg::ST_TAIL_BAD))) |-> !assembling_reg)
        else $error("assembly still open after completed message");
`endif

endmodule

@@ test/can_multi_frame_reassembler_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// can_multi_frame_reassembler_top_test
// self-checking bench for the can multi-frame reassembler: a queue of frames
// and read items feeds a handshake driver, a bit-accurate predictor runs on
// every accepted item, and a monitor checks each result against the oldest
// expectation while both sides idle in random bursts
// ----------------------------------------------------------------------------
module can_multi_frame_reassembler_top_test;

    localparam int BUF_BYTES    = cmfr_pkg::BUF_BYTES_DEF;
    localparam int LANES        = cmfr_pkg::LANES;
    localparam int TAIL_LEN     = cmfr_pkg::TAIL_LEN;
    localparam int GROUPS       = BUF_BYTES / LANES;
    localparam int ITEM_TARGET  = 1200;
    localparam int QUIET_TAIL   = 150;     // last items run with no idling
    localparam int DRAIN_CYCLES = 16;      // well past the pipeline latency
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SHOW_LIMIT   = 10;

    // one input item as it sits on the ports
    typedef struct packed {
        logic        func;
        logic [3:0]  frame_len;
        logic [63:0] frame_bytes;
        logic [4:0]  read_word;
    } can_item_t;

    // queued item, optionally held back until every result is in
    typedef struct packed {
        can_item_t item;
        logic      drain_first;
    } queued_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  message_length;
        logic [63:0] read_bytes;
    } reasm_result_t;

    // reassembly state, plus a mark per byte that has ever been written
    typedef struct packed {
        logic                      assembling;
        logic [7:0]                payload_length;
        logic [8:0]                write_position;
        logic [BUF_BYTES-1:0]      written;
        logic [BUF_BYTES-1:0][7:0] store;
    } reasm_state_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        func = 1'b0;
    logic [3:0]  frame_len = '0;
    logic [63:0] frame_bytes = '0;
    logic [4:0]  read_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [7:0]  message_length;
    logic [63:0] read_bytes;

    queued_item_t  pending [$];
    reasm_result_t expected_results [$];
    reasm_state_t  gen_state;      // tracks written bytes while building stimulus
    reasm_state_t  live_state;     // advanced on every accepted item
    can_item_t     on_bus;
    logic          drain_next = 1'b0;
    int            item_total = 0;
    int            total_items = 0;
    int            results_checked = 0;
    int            mismatches = 0;
    int            cycles = 0;
    int            idle_left = 0;
    int            stall_left = 0;

    always #10 clk = ~clk;

    can_multi_frame_reassembler_top #(
        .BUF_BYTES(BUF_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .func(func),
        .frame_len(frame_len),
        .frame_bytes(frame_bytes),
        .read_word(read_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .message_length(message_length),
        .read_bytes(read_bytes)
    );

    // ------------------------------------------------------------------------
    // predictor: one item in, one result out, state updated in place
    // ------------------------------------------------------------------------
    function automatic reasm_result_t reassemble_step(inout reasm_state_t s,
                                                      input can_item_t it);
        reasm_result_t r;
        logic [7:0]    b [LANES];
        int            i;
        int            addr;
        int            len;
        int            nbytes;
        int            last;
        logic          good;
        r = '0;
        r.status = cmfr_pkg::ST_IDLE;
        for (i = 0; i < LANES; i++)
        begin
            b[i] = it.frame_bytes[8*i +: 8];
        end
        if (it.func)
        begin
            // read: positions past the buffer read as zero
            for (i = 0; i < LANES; i++)
            begin
                addr = int'(it.read_word) * LANES + i;
                if (addr < BUF_BYTES)
                begin
                    r.read_bytes[8*i +: 8] = s.store[addr];
                end
            end
            r.status = cmfr_pkg::ST_READ;
        end
        else if (b[0] == cmfr_pkg::HDR_B0 && b[1] == cmfr_pkg::HDR_B1 &&
                 b[2] == cmfr_pkg::HDR_B2 && b[3] == cmfr_pkg::HDR_B3)
        begin
            // header marker checked whatever frame_len says
            len = int'({b[7], b[6]});
            if (len + TAIL_LEN > BUF_BYTES)
            begin
                r.status = cmfr_pkg::ST_HDR_BIG;     // assembly in progress left alone
            end
            else
            begin
                s.payload_length = 8'(len);
                s.write_position = '0;
                s.assembling = 1'b1;
                r.status = cmfr_pkg::ST_HDR_OK;
            end
        end
        else if (s.assembling)
        begin
            nbytes = (it.frame_len > 4'd8) ? LANES : int'(it.frame_len);
            last = int'(s.payload_length) + TAIL_LEN;
            // bytes past the end of the tail are dropped
            for (i = 0; i < nbytes; i++)
            begin
                if (int'(s.write_position) < last)
                begin
                    s.store[s.write_position] = b[i];
                    s.written[s.write_position] = 1'b1;
                    s.write_position = s.write_position + 9'd1;
                end
            end
            if (int'(s.write_position) == last)
            begin
                good = s.store[int'(s.payload_length)]     == cmfr_pkg::TAIL_B0 &&
                       s.store[int'(s.payload_length) + 1] == cmfr_pkg::TAIL_B1 &&
                       s.store[int'(s.payload_length) + 2] == cmfr_pkg::TAIL_B2 &&
                       s.store[int'(s.payload_length) + 3] == cmfr_pkg::TAIL_B3;
                r.status = good ? cmfr_pkg::ST_MSG_OK : cmfr_pkg::ST_TAIL_BAD;
                s.assembling = 1'b0;
            end
        end
        r.message_length = s.payload_length;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------------
    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic can_item_t data_frame(int n, logic [63:0] bytes);
        can_item_t it;
        it.func = 1'b0;
        it.frame_len = 4'(n);
        it.frame_bytes = bytes;
        it.read_word = 5'($urandom);
        return it;
    endfunction

    // header: marker in bytes 0..3, random bytes 4..5, length in bytes 6..7
    function automatic can_item_t header_frame(int len, int n);
        logic [63:0] w;
        w = random_word();
        w[31:0] = {cmfr_pkg::HDR_B3, cmfr_pkg::HDR_B2, cmfr_pkg::HDR_B1, cmfr_pkg::HDR_B0};
        w[63:48] = 16'(len);
        return data_frame(n, w);
    endfunction

    function automatic can_item_t read_item(int grp);
        can_item_t it;
        it.func = 1'b1;
        it.frame_len = 4'($urandom);
        it.frame_bytes = random_word();
        it.read_word = 5'(grp);
        return it;
    endfunction

    // random eight-byte group whose bytes have all been written, or -1
    function automatic int readable_group();
        int ok [$];
        int g;
        for (g = 0; g < GROUPS; g++)
        begin
            if (&gen_state.written[g*LANES +: LANES])
            begin
                ok.push_back(g);
            end
        end
        if (ok.size() == 0)
        begin
            return -1;
        end
        return ok[$urandom_range(0, ok.size() - 1)];
    endfunction

    task automatic push_item(can_item_t it);
        queued_item_t  q;
        reasm_result_t r;
        logic          was_assembling;
        was_assembling = gen_state.assembling;
        r = reassemble_step(gen_state, it);
        q.item = it;
        q.drain_first = drain_next;
        drain_next = 1'b0;
        pending.push_back(q);
        // a data frame with no message open is only ignored
        if (it.func || was_assembling || r.status != cmfr_pkg::ST_IDLE)
        begin
            item_total++;
        end
    endtask

    // header, payload and tail cut into frames of random size; may be cut
    // short, broken by oversized headers or carry a damaged tail
    task automatic send_message(int len, bit good_tail, bit may_break);
        logic [7:0]  body [$];
        logic [63:0] w;
        int          i;
        int          n;
        int          pick;
        push_item(header_frame(len, $urandom_range(0, 15)));
        for (i = 0; i < len; i++)
        begin
            body.push_back(8'($urandom));
        end
        body.push_back(cmfr_pkg::TAIL_B0);
        body.push_back(cmfr_pkg::TAIL_B1);
        body.push_back(cmfr_pkg::TAIL_B2);
        body.push_back(cmfr_pkg::TAIL_B3);
        if (!good_tail)
        begin
            pick = len + $urandom_range(0, TAIL_LEN - 1);
            body[pick] = body[pick] ^ 8'($urandom_range(1, 255));
        end
        while (body.size() > 0)
        begin
            pick = $urandom_range(0, 99);
            if (may_break && pick < 3)
            begin
                return;     // left open, the next header restarts
            end
            if (may_break && pick < 6)
            begin
                push_item(header_frame($urandom_range(BUF_BYTES - TAIL_LEN + 1, 65535),
                                       $urandom_range(0, 15)));
            end
            n = (pick < 10) ? 0 : $urandom_range(1, LANES);
            w = random_word();
            for (i = 0; i < n && body.size() > 0; i++)
            begin
                w[8*i +: 8] = body.pop_front();
            end
            push_item(data_frame((n == LANES && pick > 90) ? $urandom_range(9, 15) : n, w));
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: next queued item goes out once the current one is taken
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : sender
        queued_item_t  nxt;
        reasm_result_t r;
        logic          take;
        logic          next_valid;
        take = in_valid && in_ready;
        if (take)
        begin
            r = reassemble_step(live_state, on_bus);
            expected_results.push_back(r);
        end
        if (rst_n && (!in_valid || take))
        begin
            next_valid = 1'b0;
            if (idle_left > 0)
            begin
                idle_left--;
            end
            // drain point: hold off until all results are back
            else if (pending.size() > 0 &&
                     !(pending[0].drain_first && expected_results.size() > 0))
            begin
                nxt = pending.pop_front();
                on_bus = nxt.item;
                func <= nxt.item.func;
                frame_len <= nxt.item.frame_len;
                frame_bytes <= nxt.item.frame_bytes;
                read_word <= nxt.item.read_word;
                next_valid = 1'b1;
                if (pending.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                begin
                    idle_left = $urandom_range(1, 16);
                end
            end
            in_valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: check each result, stall the output in random bursts
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : receiver
        reasm_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                    begin
                        $display("unexpected result: status %0d length %0d bytes %h",
                                 status, message_length, read_bytes);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status || message_length !== want.message_length ||
                        read_bytes !== want.read_bytes)
                    begin
                        mismatches++;
                        if (mismatches <= SHOW_LIMIT)
                        begin
                            $display("result %0d: expected status %0d length %0d bytes %h",
                                     results_checked, want.status, want.message_length,
                                     want.read_bytes);
                            $display("result %0d: got      status %0d length %0d bytes %h",
                                     results_checked, status, message_length, read_bytes);
                        end
                    end
                    results_checked++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (pending.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                begin
                    stall_left = $urandom_range(1, 16);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int   kind;
        int   grp;
        int   msg_len;
        logic mid_drained;
        mid_drained = 1'b0;
        gen_state = '0;
        live_state = '0;

        // data frame with no message open is ignored
        push_item(data_frame(8, 64'h0123_4567_89ab_cdef));
        // empty payload with a good tail
        push_item(header_frame(0, 8));
        push_item(data_frame(4, {32'h0, cmfr_pkg::TAIL_B3, cmfr_pkg::TAIL_B2,
                                 cmfr_pkg::TAIL_B1, cmfr_pkg::TAIL_B0}));
        // header found with frame_len zero, then a bad tail in a frame_len
        // above eight whose extra bytes are dropped
        push_item(header_frame(0, 0));
        push_item(data_frame(15, {32'hffff_ffff, cmfr_pkg::TAIL_B0, cmfr_pkg::TAIL_B1,
                                  cmfr_pkg::TAIL_B0, cmfr_pkg::TAIL_B1}));
        // oversized headers, smallest and largest length
        push_item(header_frame(BUF_BYTES - TAIL_LEN + 1, 8));
        push_item(header_frame(65535, 8));
        // four-byte payload interrupted by an empty frame and an oversized
        // header, which must not disturb it
        push_item(header_frame(4, 8));
        push_item(data_frame(0, random_word()));
        push_item(data_frame(3, 64'hffff_ffff_ff5a_a5c3));
        push_item(header_frame(300, 3));
        push_item(data_frame(5, {24'h0, cmfr_pkg::TAIL_B3, cmfr_pkg::TAIL_B2,
                                 cmfr_pkg::TAIL_B1, cmfr_pkg::TAIL_B0, 8'h00}));
        push_item(read_item(0));
        // header during assembly starts over, surplus after the tail dropped
        push_item(header_frame(10, 8));
        push_item(data_frame(8, 64'h0011_2233_4455_6677));
        push_item(header_frame(2, 8));
        push_item(data_frame(8, {8'hee, 8'hdd, cmfr_pkg::TAIL_B3, cmfr_pkg::TAIL_B2,
                                 cmfr_pkg::TAIL_B1, cmfr_pkg::TAIL_B0, 8'hff, 8'h80}));
        push_item(read_item(0));

        // random part starts after a full drain, with a message filling the
        // whole buffer so every group becomes readable
        drain_next = 1'b1;
        send_message(BUF_BYTES - TAIL_LEN, 1'b1, 1'b0);
        while (item_total < ITEM_TARGET)
        begin
            if (!mid_drained && item_total >= ITEM_TARGET / 2)
            begin
                drain_next = 1'b1;
                mid_drained = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                // mostly short messages, now and then up to the largest
                msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, BUF_BYTES - TAIL_LEN)
                                                      : $urandom_range(0, 24);
                send_message(msg_len, $urandom_range(0, 5) != 0, 1'b1);
            end
            else if (kind < 75)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    grp = readable_group();
                    if (grp >= 0)
                    begin
                        push_item(read_item(grp));
                    end
                end
            end
            else if (kind < 90)
            begin
                push_item(data_frame($urandom_range(0, 15), random_word()));
            end
            else
            begin
                push_item(header_frame($urandom_range(BUF_BYTES - TAIL_LEN + 1, 65535),
                                       $urandom_range(0, 15)));
            end
        end
        total_items = pending.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // every item gives one result
        while (results_checked < total_items)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
